/* rtl/acfp_pkg.sv */
// ----------------------------------------------------------------------------
// acfp_pkg
// Shared types, constants and helpers of the ASCII command frame parser.
// ----------------------------------------------------------------------------
package acfp_pkg;

	localparam int unsigned BUFFER_BYTES_DEF = 64;
	localparam int unsigned ACTION_CHARS_DEF = 4;
	localparam int unsigned QUEUE_DEPTH      = 2;
	localparam int unsigned QUEUE_LEVEL_W    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] FRAME_START = 8'h40;
	localparam logic [7:0] FIELD_SEP   = 8'h2c;
	localparam logic [7:0] MISSING     = 8'hff;

	localparam logic [7:0] TERMINATOR_RESET   = 8'd10;
	localparam logic [2:0] ACTION_LIMIT_RESET = 3'd4;

	localparam logic CFG_TERMINATOR   = 1'b0;
	localparam logic CFG_ACTION_LIMIT = 1'b1;

	localparam logic [2:0] FIELD_ADDR   = 3'd0;
	localparam logic [2:0] FIELD_ACTION = 3'd1;
	localparam logic [2:0] FIELD_ARG    = 3'd2;
	localparam logic [2:0] FIELD_CHECK  = 3'd3;
	localparam logic [2:0] FIELD_EXTRA  = 3'd4;

	localparam logic [1:0] STATUS_VALID    = 2'd0;
	localparam logic [1:0] STATUS_MISMATCH = 2'd1;
	localparam logic [1:0] STATUS_NO_COMMA = 2'd2;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_TERM  = 2'd1,
		KIND_COMMA = 2'd2,
		KIND_OTHER = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic       is_hex;
		logic [3:0] digit;
		logic [7:0] data;
		logic [2:0] lim;
	} item_t;

	typedef struct packed {
		logic [7:0]  address;
		logic [31:0] action_text;
		logic [2:0]  action_length;
		logic [15:0] argument;
		logic [7:0]  received_check;
		logic [7:0]  computed_check;
		logic [1:0]  status;
	} result_t;

	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [4:0] r;
		r = 5'h10;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b0, 4'(b - 8'h30)};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r = {1'b0, 4'(b - 8'h61 + 8'd10)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r = {1'b0, 4'(b - 8'h41 + 8'd10)};
		end
		return r;
	endfunction

endpackage

/* rtl/ascii_command_frame_parser.sv */
// ----------------------------------------------------------------------------
// ascii_command_frame_parser
// Parses '@addr,action,arg,check' frames from a byte stream into results.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle and sustains that rate indefinitely as
// long as results are taken; a frame's terminator byte is first registered in
// the two-entry byte queue, and the back end registers the result when it pops
// that byte from the queue. The input stalls only when the result register is
// held by the downstream side and the queue has filled behind it.
module ascii_command_frame_parser #(
	parameter int unsigned BUFFER_BYTES = acfp_pkg::BUFFER_BYTES_DEF,
	parameter int unsigned ACTION_CHARS = acfp_pkg::ACTION_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  address,
	output logic [31:0] action_text,
	output logic [2:0]  action_length,
	output logic [15:0] argument,
	output logic [7:0]  received_check,
	output logic [7:0]  computed_check,
	output logic [1:0]  status
);
	import acfp_pkg::*;

	item_t                    item;
	item_t                    head;
	logic                     full;
	logic                     empty;
	logic                     q_pop;
	logic [QUEUE_LEVEL_W-1:0] q_level;
	result_t                  res;

	assign in_ready = !full;

	acfp_front #(
		.ACTION_CHARS(ACTION_CHARS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.rx_byte(rx_byte),
		.item(item)
	);

	acfp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(in_valid && in_ready),
		.push_item(item),
		.full(full),
		.pop(q_pop),
		.empty(empty),
		.head(head),
		.level(q_level)
	);

	acfp_back #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(empty),
		.head(head),
		.pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.res(res)
	);

	assign address        = res.address;
	assign action_text    = res.action_text;
	assign action_length  = res.action_length;
	assign argument       = res.argument;
	assign received_check = res.received_check;
	assign computed_check = res.computed_check;
	assign status         = res.status;

`ifndef SYNTHESIS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= QUEUE_LEVEL_W'(QUEUE_DEPTH))
		else $error("Byte queue holds more entries than its depth.");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_level != '0)
		else $error("Byte queue popped while empty.");

	a_no_comma: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_NO_COMMA |-> address == MISSING && action_length == '0)
		else $error("Frame without a comma reports fields.");

	a_valid_check: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_VALID |-> received_check == computed_check)
		else $error("Valid status with differing check values.");
`endif

endmodule

/* rtl/acfp_front.sv */
// ----------------------------------------------------------------------------
// acfp_front
// Holds the configuration registers and classifies each received byte.
// ----------------------------------------------------------------------------
module acfp_front #(
	parameter int unsigned ACTION_CHARS = acfp_pkg::ACTION_CHARS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data,
	input  logic [7:0]          rx_byte,
	output acfp_pkg::item_t     item
);
	import acfp_pkg::*;

	localparam logic [2:0] ACT_MAX = (ACTION_CHARS < 4) ? 3'(ACTION_CHARS) : 3'd4;

	logic [7:0] terminator_q;
	logic [2:0] action_limit_q;
	logic [4:0] hex;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			terminator_q   <= TERMINATOR_RESET;
			action_limit_q <= ACTION_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TERMINATOR:   terminator_q   <= cfg_data;
				CFG_ACTION_LIMIT: action_limit_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign hex = hex_decode(rx_byte);

	always_comb begin
		item.data   = rx_byte;
		item.is_hex = ~hex[4];
		item.digit  = hex[3:0];
		item.lim    = (action_limit_q < ACT_MAX) ? action_limit_q : ACT_MAX;
		if (rx_byte == FRAME_START) begin
			item.kind = KIND_START;
		end else if (rx_byte == terminator_q) begin
			item.kind = KIND_TERM;
		end else if (rx_byte == FIELD_SEP) begin
			item.kind = KIND_COMMA;
		end else begin
			item.kind = KIND_OTHER;
		end
	end

endmodule

/* rtl/acfp_queue.sv */
// ----------------------------------------------------------------------------
// acfp_queue
// Short first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module acfp_queue (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  acfp_pkg::item_t                      push_item,
	output logic                                 full,
	input  logic                                 pop,
	output logic                                 empty,
	output acfp_pkg::item_t                      head,
	output logic [acfp_pkg::QUEUE_LEVEL_W-1:0]   level
);
	import acfp_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

	item_t                    mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]         wr_ptr_q;
	logic [PTR_W-1:0]         rd_ptr_q;
	logic [QUEUE_LEVEL_W-1:0] level_q;

	assign full  = (level_q == QUEUE_LEVEL_W'(QUEUE_DEPTH));
	assign empty = (level_q == '0);
	assign head  = mem_q[rd_ptr_q];
	assign level = level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/acfp_back.sv */
// ----------------------------------------------------------------------------
// acfp_back
// Runs the frame state for each queued byte and holds the result register.
// ----------------------------------------------------------------------------
module acfp_back #(
	parameter int unsigned BUFFER_BYTES = acfp_pkg::BUFFER_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  acfp_pkg::item_t   head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output acfp_pkg::result_t res
);
	import acfp_pkg::*;

	localparam int unsigned CNT_W = $clog2(BUFFER_BYTES);

	logic              in_frame_q;
	logic [CNT_W-1:0]  byte_count_q;
	logic [2:0]        field_q;
	logic              stopped_q;
	logic [7:0]        addr_q;
	logic [31:0]       act_q;
	logic [2:0]        act_cnt_q;
	logic [15:0]       arg_q;
	logic [7:0]        chk_q;
	logic [7:0]        sum_q;
	logic [7:0]        sum_last_q;
	logic              out_valid_q;
	result_t           res_q;

	logic [CNT_W:0]    cnt_next;
	logic              overflow;
	logic              emit;
	result_t           res_d;

	assign pop       = !empty && (!out_valid_q || out_ready);
	assign cnt_next  = {1'b0, byte_count_q} + 1'b1;
	assign overflow  = (cnt_next >= (CNT_W + 1)'(BUFFER_BYTES));
	assign emit      = pop && in_frame_q && !overflow && (head.kind == KIND_TERM);
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_comb begin
		res_d.address        = (field_q >= FIELD_ACTION) ? addr_q : MISSING;
		res_d.action_text    = (field_q >= FIELD_ARG) ? act_q : '0;
		res_d.action_length  = (field_q >= FIELD_ARG) ? act_cnt_q : '0;
		res_d.argument       = (field_q >= FIELD_CHECK) ? arg_q : {8'h00, MISSING};
		res_d.received_check = (field_q >= FIELD_CHECK) ? chk_q : MISSING;
		res_d.computed_check = (field_q >= FIELD_ACTION) ? sum_last_q : 8'h00;
		if (field_q == FIELD_ADDR) begin
			res_d.status = STATUS_NO_COMMA;
		end else if (res_d.received_check == sum_last_q) begin
			res_d.status = STATUS_VALID;
		end else begin
			res_d.status = STATUS_MISMATCH;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			byte_count_q <= '0;
			field_q      <= FIELD_ADDR;
			stopped_q    <= 1'b0;
			addr_q       <= '0;
			act_q        <= '0;
			act_cnt_q    <= '0;
			arg_q        <= '0;
			chk_q        <= '0;
			sum_q        <= '0;
			sum_last_q   <= '0;
		end else if (pop) begin
			if (head.kind == KIND_START) begin
				in_frame_q   <= 1'b1;
				byte_count_q <= CNT_W'(1);
				field_q      <= FIELD_ADDR;
				stopped_q    <= 1'b0;
				addr_q       <= '0;
				act_q        <= '0;
				act_cnt_q    <= '0;
				arg_q        <= '0;
				chk_q        <= '0;
				sum_q        <= FRAME_START;
				sum_last_q   <= '0;
			end else if (in_frame_q) begin
				if (overflow || head.kind == KIND_TERM) begin
					in_frame_q <= 1'b0;
				end else begin
					byte_count_q <= cnt_next[CNT_W-1:0];
					if (head.kind == KIND_COMMA) begin
						sum_last_q <= sum_q;
						sum_q      <= sum_q + FIELD_SEP;
						stopped_q  <= 1'b0;
						if (field_q < FIELD_EXTRA) begin
							field_q <= field_q + 1'b1;
						end
					end else begin
						sum_q <= sum_q + head.data;
						if (field_q == FIELD_ACTION) begin
							if (act_cnt_q < head.lim) begin
								act_q[{act_cnt_q[1:0], 3'b000} +: 8] <= head.data;
								act_cnt_q <= act_cnt_q + 1'b1;
							end
						end else if (field_q <= FIELD_CHECK && !stopped_q) begin
							if (!head.is_hex) begin
								stopped_q <= 1'b1;
							end else begin
								case (field_q)
									FIELD_ADDR:  addr_q <= {addr_q[3:0], head.digit};
									FIELD_ARG:   arg_q  <= {arg_q[11:0], head.digit};
									FIELD_CHECK: chk_q  <= {chk_q[3:0], head.digit};
									default: ;
								endcase
							end
						end
					end
				end
			end
		end
	end

endmodule

/* sim/tb_ascii_command_frame_parser.sv */
// ----------------------------------------------------------------------------
// tb_ascii_command_frame_parser
// Self-checking testbench for the ASCII command frame parser. A few directed
// frames come first, followed by randomized byte streams: mostly well-formed
// frames with random content, plus truncated frames, overlong frames and loose
// noise. The run steps through several terminator and action-limit settings
// and several ready/valid idling mixes. A scoreboard predicts every frame
// result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module tb_ascii_command_frame_parser;
	import acfp_pkg::*;

	localparam int DRAIN_CYCLES  = 6;
	localparam int PHASES        = 9;
	localparam int PHASE_ITEMS   = 92;

	class frame_scoreboard;
		logic [7:0]  terminator;
		logic [2:0]  action_limit;
		logic        in_frame;
		logic [6:0]  byte_count;
		logic [2:0]  field_index;
		logic        digits_stopped;
		logic [7:0]  address_acc;
		logic [31:0] action_chars;
		logic [2:0]  action_count;
		logic [15:0] argument_acc;
		logic [7:0]  check_acc;
		logic [7:0]  running_sum;
		logic [7:0]  sum_at_comma;
		result_t     expected_frames[$];
		int unsigned mismatches;

		function new();
			terminator = TERMINATOR_RESET;
			action_limit = ACTION_LIMIT_RESET;
			mismatches = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			in_frame = 1'b0;
			byte_count = '0;
			field_index = FIELD_ADDR;
			digits_stopped = 1'b0;
			address_acc = '0;
			action_chars = '0;
			action_count = '0;
			argument_acc = '0;
			check_acc = '0;
			running_sum = '0;
			sum_at_comma = '0;
		endfunction

		function void write_register(logic index, logic [7:0] data);
			if (index == CFG_TERMINATOR) begin
				terminator = data;
			end else begin
				action_limit = data[2:0];
			end
		endfunction

		function logic [4:0] digit_of(logic [7:0] b);
			if (b >= "0" && b <= "9") begin
				return {1'b0, b[3:0]};
			end
			if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
				return {1'b0, 4'(b[2:0] + 4'd9)};
			end
			return 5'h10;
		endfunction

		function logic [2:0] kept_chars();
			int unsigned lim;
			lim = action_limit;
			if (lim > ACTION_CHARS_DEF) begin
				lim = ACTION_CHARS_DEF;
			end
			if (lim > 4) begin
				lim = 4;
			end
			return 3'(lim);
		endfunction

		function void accept_byte(logic [7:0] b);
			logic [7:0] count;
			logic [4:0] digit;
			result_t    r;
			if (b == FRAME_START) begin
				clear_frame();
				in_frame = 1'b1;
				byte_count = 7'd1;
				running_sum = FRAME_START;
				return;
			end
			if (!in_frame) begin
				return;
			end
			count = {1'b0, byte_count} + 8'd1;
			if (count >= BUFFER_BYTES_DEF) begin
				clear_frame();
				return;
			end
			byte_count = count[6:0];

			if (b == terminator) begin
				r.address = (field_index >= FIELD_ACTION) ? address_acc : MISSING;
				r.action_text = (field_index >= FIELD_ARG) ? action_chars : '0;
				r.action_length = (field_index >= FIELD_ARG) ? action_count : '0;
				r.argument = (field_index >= FIELD_CHECK) ? argument_acc : {8'h00, MISSING};
				r.received_check = (field_index >= FIELD_CHECK) ? check_acc : MISSING;
				r.computed_check = (field_index >= FIELD_ACTION) ? sum_at_comma : '0;
				if (field_index == FIELD_ADDR) begin
					r.status = STATUS_NO_COMMA;
				end else if (r.received_check == sum_at_comma) begin
					r.status = STATUS_VALID;
				end else begin
					r.status = STATUS_MISMATCH;
				end
				expected_frames.push_back(r);
				clear_frame();
				return;
			end

			if (b == FIELD_SEP) begin
				sum_at_comma = running_sum;
				running_sum = running_sum + FIELD_SEP;
				if (field_index < FIELD_EXTRA) begin
					field_index = field_index + 3'd1;
				end
				digits_stopped = 1'b0;
				return;
			end

			running_sum = running_sum + b;
			if (field_index == FIELD_ACTION) begin
				if (action_count < kept_chars()) begin
					action_chars[8*action_count +: 8] = b;
					action_count = action_count + 3'd1;
				end
				return;
			end
			if (field_index > FIELD_CHECK || digits_stopped) begin
				return;
			end
			digit = digit_of(b);
			if (digit[4]) begin
				digits_stopped = 1'b1;
				return;
			end
			case (field_index)
				FIELD_ADDR: begin
					address_acc = {address_acc[3:0], digit[3:0]};
				end
				FIELD_ARG: begin
					argument_acc = {argument_acc[11:0], digit[3:0]};
				end
				default: begin
					check_acc = {check_acc[3:0], digit[3:0]};
				end
			endcase
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_frames.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				mismatches++;
				return;
			end
			want = expected_frames.pop_front();
			compare_field("address", want.address, got.address);
			compare_field("action_text", want.action_text, got.action_text);
			compare_field("action_length", want.action_length, got.action_length);
			compare_field("argument", want.argument, got.argument);
			compare_field("received_check", want.received_check, got.received_check);
			compare_field("computed_check", want.computed_check, got.computed_check);
			compare_field("status", want.status, got.status);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  address;
	logic [31:0] action_text;
	logic [2:0]  action_length;
	logic [15:0] argument;
	logic [7:0]  received_check;
	logic [7:0]  computed_check;
	logic [1:0]  status;
	result_t     observed;

	frame_scoreboard sb;
	logic [7:0]      frame_bytes[$];
	logic [7:0]      term_now;
	int unsigned     frame_items;
	int unsigned     send_idle_pct;
	int unsigned     recv_idle_pct;

	logic [7:0] phase_term [PHASES] = '{8'h0a, 8'h0d, 8'hff, 8'h00, FIELD_SEP, 8'h41,
		FRAME_START, 8'h0a, 8'h80};
	logic [2:0] phase_limit [PHASES] = '{3'd4, 3'd1, 3'd3, 3'd2, 3'd0, 3'd7, 3'd5,
		3'd4, 3'd6};

	ascii_command_frame_parser u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.address        (address),
		.action_text    (action_text),
		.action_length  (action_length),
		.argument       (argument),
		.received_check (received_check),
		.computed_check (computed_check),
		.status         (status)
	);

	assign observed = {address, action_text, action_length, argument, received_check,
		computed_check, status};

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_result(observed);
		end
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [7:0] hex_char(logic [3:0] n);
		if (n < 4'd10) begin
			return 8'h30 + {4'd0, n};
		end
		return ($urandom_range(1) ? 8'h61 : 8'h41) + {4'd0, n} - 8'd10;
	endfunction

	function automatic logic [7:0] filler_char();
		logic [7:0] c;
		do begin
			if ($urandom_range(9) < 7) begin
				c = 8'($urandom_range(8'h7e, 8'h20));
			end else begin
				c = 8'($urandom_range(255));
			end
		end while (c == FRAME_START || c == FIELD_SEP || c == term_now);
		return c;
	endfunction

	// A frame with random fields; the check usually matches the sum taken at the
	// third comma, but is sometimes wrong, empty, padded or followed by junk.
	function automatic void build_frame();
		logic [7:0] sum;
		int         n;
		int         i;
		int         mode;
		frame_bytes.delete();
		frame_bytes.push_back(FRAME_START);
		n = $urandom_range(3);
		for (i = 0; i < n; i++) frame_bytes.push_back(hex_char(4'($urandom_range(15))));
		frame_bytes.push_back(FIELD_SEP);
		n = $urandom_range(6);
		for (i = 0; i < n; i++) frame_bytes.push_back(filler_char());
		frame_bytes.push_back(FIELD_SEP);
		n = $urandom_range(5);
		for (i = 0; i < n; i++) frame_bytes.push_back(hex_char(4'($urandom_range(15))));
		sum = '0;
		for (i = 0; i < frame_bytes.size(); i++) sum = sum + frame_bytes[i];
		frame_bytes.push_back(FIELD_SEP);
		mode = $urandom_range(9);
		if (mode == 0) begin
			sum = sum ^ 8'($urandom_range(255, 1));
		end
		if (mode == 2) begin
			frame_bytes.push_back(hex_char(4'($urandom_range(15))));
		end
		if (mode != 1) begin
			frame_bytes.push_back(hex_char(sum[7:4]));
			frame_bytes.push_back(hex_char(sum[3:0]));
		end
		if (mode == 3) begin
			frame_bytes.push_back("G");
		end
		if ($urandom_range(9) == 0) begin
			frame_bytes.push_back(FIELD_SEP);
			n = $urandom_range(2);
			for (i = 0; i < n; i++) frame_bytes.push_back(hex_char(4'($urandom_range(15))));
		end
		frame_bytes.push_back(term_now);
	endfunction

	task automatic send_byte(logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.accept_byte(b);
		@(negedge clk);
	endtask

	task automatic send_frame(bit counted);
		int i;
		for (i = 0; i < frame_bytes.size(); i++) begin
			send_byte(frame_bytes[i]);
			if (counted) begin
				frame_items++;
			end
		end
	endtask

	task automatic send_text(string s, bit add_check, bit add_term);
		logic [7:0] sum;
		int         i;
		frame_bytes.delete();
		sum = '0;
		for (i = 0; i < s.len(); i++) begin
			frame_bytes.push_back(s[i]);
			if (i < s.len() - 1) begin
				sum = sum + s[i];
			end
		end
		if (add_check) begin
			frame_bytes.push_back(hex_char(sum[7:4]));
			frame_bytes.push_back(hex_char(sum[3:0]));
		end
		if (add_term) begin
			frame_bytes.push_back(term_now);
		end
		send_frame(1'b1);
	endtask

	// Address digits only, so the frame length is fully under control.
	task automatic send_long(int digits);
		int i;
		frame_bytes.delete();
		frame_bytes.push_back(FRAME_START);
		for (i = 0; i < digits; i++) frame_bytes.push_back(hex_char(4'($urandom_range(15))));
		frame_bytes.push_back(term_now);
		frame_bytes.push_back(filler_char());
		send_frame(1'b1);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (sb.expected_frames.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic configure(logic [7:0] term, logic [2:0] lim);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_TERMINATOR;
		cfg_data <= term;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_register(CFG_TERMINATOR, term);
		term_now = term;
		@(negedge clk);
		cfg_index <= CFG_ACTION_LIMIT;
		cfg_data <= {5'd0, lim};
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_register(CFG_ACTION_LIMIT, {5'd0, lim});
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_stream(int unsigned quota);
		int unsigned start;
		int          pick;
		int          cut;
		int          n;
		int          i;
		start = frame_items;
		while (frame_items - start < quota) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				frame_bytes.delete();
				n = $urandom_range(6, 1);
				for (i = 0; i < n; i++) frame_bytes.push_back(8'($urandom_range(255)));
				send_frame(1'b0);
			end else if (pick < 10) begin
				send_long($urandom_range(66, 58));
			end else begin
				build_frame();
				if (pick < 22) begin
					cut = $urandom_range(frame_bytes.size() - 1, 1);
					while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
					if ($urandom_range(1)) begin
						frame_bytes.push_back(term_now);
					end
				end
				send_frame(1'b1);
			end
			if ($urandom_range(99) < 3) begin
				wait_drained();
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TERMINATOR;
		cfg_data = '0;
		in_valid = 1'b0;
		rx_byte = '0;
		term_now = TERMINATOR_RESET;
		frame_items = 0;
		send_idle_pct = 30;
		recv_idle_pct = 61;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_text("@ff,RDWR,ffff,", 1'b1, 1'b1);
		send_text("@1A2,Go,AbCd9,", 1'b1, 1'b1);
		send_text("@,,,", 1'b1, 1'b1);
		send_text("@12,AB,34,00", 1'b0, 1'b1);
		send_text("zz@7", 1'b0, 1'b1);
		send_text("@5,xyz", 1'b0, 1'b1);
		send_text("@5,xy,9g8", 1'b0, 1'b1);
		send_text("@1,a,2,3,4,5", 1'b0, 1'b1);
		send_text("@12,ab@34,cd,56,", 1'b1, 1'b1);
		send_long(61);
		send_long(62);

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase < 3) begin
				send_idle_pct = 30;
				recv_idle_pct = 61;
			end else if (phase < 6) begin
				send_idle_pct = 61;
				recv_idle_pct = 30;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (phase > 0) begin
				wait_drained();
				configure(phase_term[phase], phase_limit[phase]);
			end
			send_random_stream(PHASE_ITEMS);
		end

		wait_drained();
		if (sb.expected_frames.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, sb.expected_frames.size());
			sb.mismatches++;
		end
		if (sb.mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
